/* sv/etok_pkg.sv */
// ----------------------------------------------------------------------------
// etok_pkg
// Shared types, codes and character classes of the expression tokenizer.
// ----------------------------------------------------------------------------
package etok_pkg;

   // token kinds
   localparam logic [2:0] K_WORD = 3'd0;
   localparam logic [2:0] K_INT  = 3'd1;
   localparam logic [2:0] K_DEC  = 3'd2;
   localparam logic [2:0] K_SIGN = 3'd3;
   localparam logic [2:0] K_ERR  = 3'd4;

   // open token modes
   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_WORD = 2'd1;
   localparam logic [1:0] M_NUM  = 2'd2;
   localparam logic [1:0] M_SIGN = 2'd3;

   // saturation bound of position and length
   localparam logic [15:0] POS_CAP = 16'hFFFF;

   // characters with a special role
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_CARET      = 8'h5E;
   localparam logic [7:0] CH_PERCENT    = 8'h25;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_TAB        = 8'h09;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] tok_start;
      logic [15:0] tok_len;
      logic [7:0]  sign_first;
      logic [7:0]  sign_second;
      logic        text_done;
      logic        run_last;
   } etok_result_type;

   // results of one accepted byte, in order
   typedef struct packed {
      logic [1:0]      count;
      etok_result_type slot0;
      etok_result_type slot1;
   } etok_push_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             c == CH_UNDERSCORE;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_single(input logic [7:0] c);
      return c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D ||
             c == 8'h7B || c == 8'h7D || c == CH_CARET || c == CH_PERCENT ||
             c == 8'h3B || c == 8'h2C;
   endfunction

   function automatic logic is_pairable(input logic [7:0] c);
      return c == 8'h3C || c == 8'h3E || c == CH_EQUAL || c == 8'h21 ||
             c == 8'h2B || c == 8'h2D || c == 8'h2F || c == 8'h2A ||
             c == CH_COLON;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_NEWLINE || c == CH_TAB;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v < POS_CAP) ? v + 16'd1 : POS_CAP;
   endfunction

   // token that closes an open word, number or pending sign
   function automatic etok_result_type flush_token(
      input logic [1:0]  mode,
      input logic [15:0] start,
      input logic [15:0] len,
      input logic        dot,
      input logic [7:0]  held
   );
      etok_result_type r;
      r = '0;
      r.tok_start = start;
      case (mode)
         M_WORD: begin
            r.kind    = K_WORD;
            r.tok_len = len;
         end
         M_NUM: begin
            r.kind    = dot ? K_DEC : K_INT;
            r.tok_len = len;
         end
         M_SIGN: begin
            r.kind       = (held == CH_COLON) ? K_ERR : K_SIGN;
            r.tok_len    = 16'd1;
            r.sign_first = held;
         end
         default: begin
            r.kind = K_ERR;
         end
      endcase
      return r;
   endfunction

endpackage

/* sv/etok_if.sv */
// ----------------------------------------------------------------------------
// etok_if
// Valid/ready channels of the expression tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface etok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_text;

   modport source (output valid, ch, end_of_text, input ready);
   modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface etok_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] tok_start;
   logic [15:0] tok_len;
   logic [7:0]  sign_first;
   logic [7:0]  sign_second;
   logic        text_done;
   logic        run_last;

   modport source (output valid, kind, tok_start, tok_len, sign_first, sign_second,
                   text_done, run_last, input ready);
   modport sink   (input valid, kind, tok_start, tok_len, sign_first, sign_second,
                   text_done, run_last, output ready);
endinterface

/* sv/etok_core.sv */
// ----------------------------------------------------------------------------
// etok_core
// Lexer state and the per-byte step: up to two tokens per accepted byte.
// ----------------------------------------------------------------------------
module etok_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             ch,
   input  logic                   end_of_text,
   output etok_pkg::etok_push_type push
);
   import etok_pkg::*;

   logic [1:0]  mode_ff,  mode_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] len_ff,   len_in;
   logic        dot_ff,   dot_in;
   logic [7:0]  held_ff,  held_in;
   logic [15:0] pos_ff,   pos_in;

   logic            used;
   logic [1:0]      mode_mid;
   logic [15:0]     start_mid;
   logic [15:0]     len_mid;
   logic            dot_mid;
   logic [7:0]      held_mid;
   logic            va, vb, vc;
   etok_result_type ra, rb, rc;
   logic            alnum;

   assign alnum = is_alpha(ch) || is_digit(ch);

   // step: close or extend the open token, then start from the new byte
   always_comb begin
      used      = 1'b0;
      mode_mid  = mode_ff;
      start_mid = start_ff;
      len_mid   = len_ff;
      dot_mid   = dot_ff;
      held_mid  = held_ff;
      va        = 1'b0;
      ra        = flush_token(mode_ff, start_ff, len_ff, dot_ff, held_ff);
      vb        = 1'b0;
      rb        = '0;

      // open token
      case (mode_ff)
         M_WORD: begin
            if (alnum) begin
               len_mid = sat_inc(len_ff);
               used    = 1'b1;
            end else begin
               va       = 1'b1;
               mode_mid = M_IDLE;
            end
         end
         M_NUM: begin
            if (alnum || ch == CH_DOT) begin
               if (ch == CH_DOT) dot_mid = 1'b1;
               len_mid = sat_inc(len_ff);
               used    = 1'b1;
            end else begin
               va       = 1'b1;
               mode_mid = M_IDLE;
            end
         end
         M_SIGN: begin
            va       = 1'b1;
            mode_mid = M_IDLE;
            if (ch == CH_EQUAL) begin
               ra.kind        = K_SIGN;
               ra.tok_len     = 16'd2;
               ra.sign_second = CH_EQUAL;
               used           = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // byte as start of new text
      rb.tok_start  = pos_ff;
      rb.tok_len    = 16'd1;
      rb.sign_first = ch;
      if (!used) begin
         if (is_alpha(ch)) begin
            mode_mid  = M_WORD;
            start_mid = pos_ff;
            len_mid   = 16'd1;
         end else if (is_digit(ch)) begin
            mode_mid  = M_NUM;
            start_mid = pos_ff;
            len_mid   = 16'd1;
            dot_mid   = 1'b0;
         end else if (is_space(ch)) begin
            mode_mid = mode_mid;
         end else if (is_single(ch)) begin
            vb      = 1'b1;
            rb.kind = K_SIGN;
         end else if (is_pairable(ch)) begin
            mode_mid  = M_SIGN;
            held_mid  = ch;
            start_mid = pos_ff;
         end else begin
            vb      = 1'b1;
            rb.kind = K_ERR;
         end
      end

      // end of text flush
      vc = end_of_text && (mode_mid != M_IDLE);
      rc = flush_token(mode_mid, start_mid, len_mid, dot_mid, held_mid);
   end

   // pack the emitted tokens into two slots, mark the last one
   always_comb begin
      push = '0;
      if (va) begin
         push.slot0 = ra;
         push.slot1 = vb ? rb : rc;
      end else begin
         push.slot0 = vb ? rb : rc;
         push.slot1 = rc;
      end
      push.count = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
      if (push.count == 2'd1) begin
         push.slot0.run_last  = 1'b1;
         push.slot0.text_done = end_of_text;
      end else if (push.count == 2'd2) begin
         push.slot1.run_last  = 1'b1;
         push.slot1.text_done = end_of_text;
      end
   end

   // next state
   always_comb begin
      if (end_of_text) begin
         mode_in  = M_IDLE;
         start_in = '0;
         len_in   = '0;
         dot_in   = 1'b0;
         held_in  = '0;
         pos_in   = '0;
      end else begin
         mode_in  = mode_mid;
         start_in = start_mid;
         len_in   = len_mid;
         dot_in   = dot_mid;
         held_in  = held_mid;
         pos_in   = sat_inc(pos_ff);
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         start_ff <= '0;
         len_ff   <= '0;
         dot_ff   <= 1'b0;
         held_ff  <= '0;
         pos_ff   <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         dot_ff   <= dot_in;
         held_ff  <= held_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

/* sv/etok_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// etok_rsp_fifo
// Four-entry token queue: takes up to two tokens per cycle, gives one.
// ----------------------------------------------------------------------------
module etok_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_en,
   input  etok_pkg::etok_push_type  push,
   output logic                     room,
   output logic                     out_valid,
   input  logic                     out_ready,
   output etok_pkg::etok_result_type out_data
);
   import etok_pkg::*;

   etok_result_type entry_ff [4];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] n_push;
   logic       pop;

   assign n_push    = push_en ? push.count : 2'd0;
   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 3'd0);
   assign out_data  = entry_ff[rd_ff];
   // room for the worst case of two tokens from one byte
   assign room      = (count_ff <= 3'd2);

   // pointer and fill update
   always_comb begin
      wr_in    = wr_ff + n_push;
      rd_in    = rd_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, n_push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry writes
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) entry_ff[wr_ff] <= push.slot0;
      if (n_push == 2'd2) entry_ff[wr_ff + 2'd1] <= push.slot1;
   end

endmodule

/* sv/expression_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// expression_tokenizer_unit
// Streaming lexer: source bytes in, word, number and sign tokens out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while the queue has room. A byte
// updates the lexer state in the cycle it is accepted and its tokens (none,
// one or two) are registered into a four-entry output queue; tokens leave
// one per cycle while the result side is ready. The input is ready while the
// queue holds at most two tokens, so with the result side always ready the
// unit runs at one byte per cycle until bytes that give two tokens fill the
// queue past two entries, and a stalled result side stops the input.
// Position and token length saturate at 65535; the byte marked end_of_text
// flushes any open token and returns the position to zero.
module expression_tokenizer_unit (
   input  logic             clock,
   input  logic             reset,
   etok_req_if.sink         req_ch,
   etok_rsp_if.source       rsp_ch
);
   import etok_pkg::*;

   logic            req_transfer;
   logic            room;
   etok_push_type   push;
   etok_result_type head;

   assign req_ch.ready = room;
   assign req_transfer = req_ch.valid && room;

   // lexer state and per-byte step
   etok_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (req_transfer),
      .ch          (req_ch.ch),
      .end_of_text (req_ch.end_of_text),
      .push        (push)
   );

   // token queue
   etok_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (req_transfer),
      .push      (push),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (head)
   );

   // result channel payload
   assign rsp_ch.kind        = head.kind;
   assign rsp_ch.tok_start   = head.tok_start;
   assign rsp_ch.tok_len     = head.tok_len;
   assign rsp_ch.sign_first  = head.sign_first;
   assign rsp_ch.sign_second = head.sign_second;
   assign rsp_ch.text_done   = head.text_done;
   assign rsp_ch.run_last    = head.run_last;

endmodule
